// File: rtl/core/mmcq_pkg.sv
// shared types, constants and widths for the multi-server queue event stepper
package mmcq_pkg;

  // field widths
  localparam int TIME_BITS    = 48;
  localparam int SAMPLE_BITS  = 32;
  localparam int SC_BITS      = 4;
  localparam int KIND_BITS    = 2;
  localparam int IN_SYS_BITS  = 16;
  localparam int DEP_BITS     = 32;
  localparam int ACC_BITS     = 64;

  // multiplier datapath: count operand times a time difference, in 16-bit chunks
  localparam int MUL_A_BITS   = 32;
  localparam int CHUNK_BITS   = 16;
  localparam int PP_BITS      = MUL_A_BITS + CHUNK_BITS;
  localparam int PROD_BITS    = MUL_A_BITS + TIME_BITS;

  // stream word widths
  localparam int IN_TDATA_BITS  = 2 * SAMPLE_BITS;
  localparam int OUT_FIELD_BITS = TIME_BITS + IN_SYS_BITS + DEP_BITS + 3 * ACC_BITS + 4;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

  // configuration port
  localparam int CFG_DATA_BITS  = TIME_BITS;
  localparam int CFG_INDEX_BITS = 1;

  // parameter defaults
  localparam int DEF_SERVERS    = 8;
  localparam int DEF_COUNT_BITS = 16;

  // time marks
  localparam logic [TIME_BITS-1:0] TIME_MASK  = '1;
  localparam logic [TIME_BITS-1:0] IDLE_MARK  = TIME_MASK;
  localparam logic [TIME_BITS-1:0] FINISH_MAX = TIME_MASK - TIME_BITS'(1);

  // register reset values
  localparam logic [SC_BITS-1:0]   RESET_SERVER_COUNT = 4'd2;
  localparam logic [TIME_BITS-1:0] RESET_END_TIME     = 48'd65536000000;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SERVER_COUNT = 1'b0,
    REG_END_TIME     = 1'b1
  } cfg_reg_t;

  // event kinds
  typedef enum logic [KIND_BITS-1:0] {
    KIND_ARRIVAL   = 2'd0,
    KIND_DEPARTURE = 2'd1,
    KIND_NONE      = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL_N,
    ST_WAIT_N,
    ST_MUL_Q,
    ST_WAIT_Q,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  // request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                  start;
    logic [MUL_A_BITS-1:0] mult;
    logic [TIME_BITS-1:0]  dt;
    logic [ACC_BITS-1:0]   acc;
  } mul_req_t;

  // answer from the shared multiply-accumulate unit
  typedef struct packed {
    logic                done;
    logic [ACC_BITS-1:0] sum;
  } mul_rsp_t;

endpackage

// File: rtl/core/mmcq_ram.sv
// generic single-write, single-read memory with registered read data
module mmcq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mmcq_mul.sv
// shared multiply-accumulate unit: saturating acc + mult * dt, built from 16-bit chunks of dt
module mmcq_mul (
  input  logic               clk,
  input  logic               rst,
  input  mmcq_pkg::mul_req_t req,
  output mmcq_pkg::mul_rsp_t rsp
);

  import mmcq_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd4;

  logic                  busy;
  logic [2:0]            step;
  logic                  done;
  logic [MUL_A_BITS-1:0] a_r;
  logic [TIME_BITS-1:0]  b_r;
  logic [ACC_BITS-1:0]   acc_r;
  logic [PP_BITS-1:0]    pp;
  logic [PROD_BITS-1:0]  prod;
  logic [ACC_BITS-1:0]   sum;
  logic [CHUNK_BITS-1:0] b_chunk;
  logic [PROD_BITS-1:0]  pp_shift;
  logic [ACC_BITS:0]     add_wide;
  logic [ACC_BITS-1:0]   sat_sum;

  // chunk of the time difference for this step
  always_comb begin
    unique case (step)
      3'd0:    b_chunk = b_r[CHUNK_BITS-1:0];
      3'd1:    b_chunk = b_r[2*CHUNK_BITS-1:CHUNK_BITS];
      default: b_chunk = b_r[3*CHUNK_BITS-1:2*CHUNK_BITS];
    endcase
  end

  // partial product aligned to the chunk it came from
  always_comb begin
    unique case (step)
      3'd2:    pp_shift = PROD_BITS'(pp) << CHUNK_BITS;
      3'd3:    pp_shift = PROD_BITS'(pp) << (2 * CHUNK_BITS);
      default: pp_shift = PROD_BITS'(pp);
    endcase
  end

  // saturating add of the clamped product to the accumulator
  always_comb begin
    add_wide = {1'b0, acc_r} + {1'b0, prod[ACC_BITS-1:0]};
    if ((|prod[PROD_BITS-1:ACC_BITS]) || add_wide[ACC_BITS]) begin
      sat_sum = '1;
    end else begin
      sat_sum = add_wide[ACC_BITS-1:0];
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // operands, partial products and the running product
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.mult;
      b_r   <= req.dt;
      acc_r <= req.acc;
      pp    <= '0;
      prod  <= '0;
    end else if (busy) begin
      if (step < STEP_LAST) begin
        prod <= prod + pp_shift;
      end
      if (step < 3'd3) begin
        pp <= a_r * b_chunk;
      end
      if (step == STEP_LAST) begin
        sum <= sat_sum;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.sum  = sum;

endmodule

// File: rtl/core/multi_server_queue_event_stepper.sv
// top level: M/M/c queue event stepper with server scan, shared multiplier and sequencer
// One input word drives at most one simulation event (arrival or departure) and always
// yields one result word. The block takes a word only while its sequencer is idle and
// then works through it in these states, c being the active server count (1 to SERVERS):
// IDLE takes the word, SCAN walks the c active entries of the server finish-time memory
// through its single registered read port to find the earliest busy server and the lowest
// idle one, DECIDE picks the event, the shared 32x16 multiplier forms the two time-weighted
// integrals one after the other, UPDATE applies the event and OUTPUT loads the output
// register once it is free. A word whose simulation has already reached its end time goes
// from IDLE straight to OUTPUT. The next word is taken while a result still waits at the
// output register. Configuration writes are meant for idle periods only.
module multi_server_queue_event_stepper #(
  parameter int SERVERS    = mmcq_pkg::DEF_SERVERS,
  parameter int COUNT_BITS = mmcq_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wen,
  input  logic [mmcq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mmcq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // arrival_gap[31:0], service_draw[63:32]
  input  logic [mmcq_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // event_time[47:0], in_system[63:48], served_count[95:64], area_sum[159:96],
  // queue_area[223:160], busy_sum[287:224], took_arrival_sample[288],
  // took_service_sample[289], arrival_dropped[290], finished[291], zeros above
  output logic [mmcq_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // event_kind[1:0]
  output logic [mmcq_pkg::KIND_BITS-1:0]       m_axis_tuser
);

  import mmcq_pkg::*;

  localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int SB = $clog2(SERVERS + 1);
  localparam int AW = (SB > SC_BITS) ? SB : SC_BITS;
  localparam int CW = (COUNT_BITS > SB) ? COUNT_BITS : SB;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [SC_BITS-1:0]   server_count;
  logic [TIME_BITS-1:0] end_time;

  // simulation state
  logic [SERVERS-1:0]    srv_valid;
  logic [TIME_BITS-1:0]  next_arrival_time;
  logic [TIME_BITS-1:0]  current_time;
  logic [COUNT_BITS-1:0] customer_count;
  logic [DEP_BITS-1:0]   departure_total;
  logic [ACC_BITS-1:0]   count_area;
  logic [ACC_BITS-1:0]   waiting_area;
  logic [ACC_BITS-1:0]   full_busy_total;
  logic [TIME_BITS-1:0]  full_busy_start;

  // per-word working registers
  state_t                state;
  state_t                state_next;
  logic [SAMPLE_BITS-1:0] gap_r;
  logic [SAMPLE_BITS-1:0] draw_r;
  kind_t                 ev_kind;
  logic                  took_a;
  logic                  took_s;
  logic                  dropped;
  logic [SB-1:0]         scan_cnt;
  logic                  pend;
  logic [IW-1:0]         pend_idx;
  logic [TIME_BITS-1:0]  best;
  logic [IW-1:0]         best_idx;
  logic                  idle_found;
  logic [IW-1:0]         idle_idx;
  logic                  is_arr;
  logic                  beyond;
  logic [TIME_BITS-1:0]  target;
  logic [TIME_BITS-1:0]  dt;
  logic [MUL_A_BITS-1:0] excess;

  // output register
  logic [KIND_BITS-1:0]   out_kind;
  logic [TIME_BITS-1:0]   out_time;
  logic [IN_SYS_BITS-1:0] out_in_sys;
  logic [DEP_BITS-1:0]    out_served;
  logic [ACC_BITS-1:0]    out_area;
  logic [ACC_BITS-1:0]    out_queue;
  logic [ACC_BITS-1:0]    out_busy;
  logic                   out_took_a;
  logic                   out_took_s;
  logic                   out_dropped;
  logic                   out_finished;

  // combinational helpers
  logic [SB-1:0]          c_act;
  logic [AW-1:0]          sc_ext;
  logic [CW-1:0]          cnt_ext;
  logic [CW-1:0]          c_ext;
  logic [CW-1:0]          inc_ext;
  logic [CW-1:0]          dec_ext;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [TIME_BITS-1:0]   scan_val;
  logic                   arrival_c;
  logic [TIME_BITS-1:0]   t_c;
  logic                   beyond_c;
  logic [TIME_BITS-1:0]   target_c;
  logic [TIME_BITS:0]     arr_sum;
  logic [TIME_BITS-1:0]   next_arr_c;
  logic [TIME_BITS:0]     fin_sum;
  logic [TIME_BITS-1:0]   finish_c;
  logic [TIME_BITS-1:0]   busy_diff;
  logic [ACC_BITS:0]      busy_sum_w;
  logic                   out_free;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [TIME_BITS-1:0]   ram_wdata;
  logic [TIME_BITS-1:0]   ram_rdata;
  mul_req_t               mul_req;
  mul_rsp_t               mul_rsp;

  // server finish times
  mmcq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SERVERS)
  ) u_srv_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  // shared multiply-accumulate unit
  mmcq_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // active server count, clamped to 1..SERVERS
  always_comb begin
    sc_ext = AW'(server_count);
    if (sc_ext == '0) begin
      c_act = SB'(1);
    end else if (sc_ext > AW'(SERVERS)) begin
      c_act = SB'(SERVERS);
    end else begin
      c_act = SB'(server_count);
    end
  end

  // count arithmetic and comparisons against the server count
  always_comb begin
    cnt_ext = CW'(customer_count);
    c_ext   = CW'(c_act);
    cnt_inc = customer_count + COUNT_BITS'(1);
    cnt_dec = (customer_count != '0) ? customer_count - COUNT_BITS'(1) : customer_count;
    inc_ext = CW'(cnt_inc);
    dec_ext = CW'(cnt_dec);
  end

  // scanned entry, never-written servers read as idle
  assign scan_val = srv_valid[pend_idx] ? ram_rdata : IDLE_MARK;

  // event choice
  always_comb begin
    arrival_c = (best == IDLE_MARK) || (next_arrival_time < best);
    t_c       = arrival_c ? next_arrival_time : best;
    beyond_c  = (t_c >= end_time);
    target_c  = beyond_c ? end_time : t_c;
  end

  // saturating time sums and busy-period total
  always_comb begin
    arr_sum    = {1'b0, target} + (TIME_BITS + 1)'(gap_r);
    next_arr_c = (arr_sum > {1'b0, TIME_MASK}) ? TIME_MASK : arr_sum[TIME_BITS-1:0];
    fin_sum    = {1'b0, target} + (TIME_BITS + 1)'(draw_r);
    finish_c   = (fin_sum > {1'b0, FINISH_MAX}) ? FINISH_MAX : fin_sum[TIME_BITS-1:0];
    busy_diff  = target - full_busy_start;
    busy_sum_w = {1'b0, full_busy_total} + (ACC_BITS + 1)'(busy_diff);
  end

  // finish-time write on service start or release
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = IDLE_MARK;
    if (state == ST_UPDATE && !beyond) begin
      if (is_arr) begin
        ram_waddr = idle_idx;
        ram_wdata = finish_c;
        ram_we    = (customer_count != COUNT_MAX) && (inc_ext <= c_ext) && idle_found;
      end else begin
        ram_we    = 1'b1;
        ram_wdata = (dec_ext >= c_ext) ? finish_c : IDLE_MARK;
      end
    end
  end

  // multiplier request: count integral first, then waiting integral
  always_comb begin
    mul_req.start = (state == ST_MUL_N) || (state == ST_MUL_Q);
    mul_req.dt    = dt;
    if (state == ST_MUL_Q) begin
      mul_req.mult = excess;
      mul_req.acc  = waiting_area;
    end else begin
      mul_req.mult = MUL_A_BITS'(customer_count);
      mul_req.acc  = count_area;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (current_time >= end_time) ? ST_OUTPUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == c_act && !pend) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_MUL_N;
      ST_MUL_N:  state_next = ST_WAIT_N;
      ST_WAIT_N: begin
        if (mul_rsp.done) begin
          state_next = ST_MUL_Q;
        end
      end
      ST_MUL_Q:  state_next = ST_WAIT_Q;
      ST_WAIT_Q: begin
        if (mul_rsp.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= RESET_SERVER_COUNT;
      end_time     <= RESET_END_TIME;
    end else if (cfg_wen) begin
      if (cfg_index == REG_SERVER_COUNT) begin
        server_count <= cfg_data[SC_BITS-1:0];
      end else begin
        end_time <= cfg_data[TIME_BITS-1:0];
      end
    end
  end

  // simulation state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      srv_valid         <= '0;
      next_arrival_time <= '0;
      current_time      <= '0;
      customer_count    <= '0;
      departure_total   <= '0;
      count_area        <= '0;
      waiting_area      <= '0;
      full_busy_total   <= '0;
      full_busy_start   <= '0;
    end else begin
      if (ram_we) begin
        srv_valid[ram_waddr] <= 1'b1;
      end
      if (state == ST_WAIT_N && mul_rsp.done) begin
        count_area <= mul_rsp.sum;
      end
      if (state == ST_WAIT_Q && mul_rsp.done) begin
        waiting_area <= mul_rsp.sum;
      end
      if (state == ST_UPDATE) begin
        current_time <= target;
        if (!beyond) begin
          if (is_arr) begin
            next_arrival_time <= next_arr_c;
            if (customer_count != COUNT_MAX) begin
              customer_count <= cnt_inc;
              if (inc_ext == c_ext) begin
                full_busy_start <= target;
              end
            end
          end else begin
            if (customer_count != '0) begin
              if (cnt_ext == c_ext && target >= full_busy_start) begin
                full_busy_total <= busy_sum_w[ACC_BITS] ? '1 : busy_sum_w[ACC_BITS-1:0];
              end
              customer_count <= cnt_dec;
            end
            if (departure_total != '1) begin
              departure_total <= departure_total + DEP_BITS'(1);
            end
          end
        end
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        gap_r      <= s_axis_tdata[SAMPLE_BITS-1:0];
        draw_r     <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        ev_kind    <= KIND_NONE;
        took_a     <= 1'b0;
        took_s     <= 1'b0;
        dropped    <= 1'b0;
        scan_cnt   <= '0;
        pend       <= 1'b0;
        pend_idx   <= '0;
        best       <= IDLE_MARK;
        best_idx   <= '0;
        idle_found <= 1'b0;
        idle_idx   <= '0;
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the entry the registered read port returns
        if (scan_cnt != c_act) begin
          scan_cnt <= scan_cnt + SB'(1);
          pend     <= 1'b1;
          pend_idx <= scan_cnt[IW-1:0];
        end else begin
          pend <= 1'b0;
        end
        if (pend) begin
          if (scan_val < best) begin
            best     <= scan_val;
            best_idx <= pend_idx;
          end
          if (scan_val == IDLE_MARK && !idle_found) begin
            idle_found <= 1'b1;
            idle_idx   <= pend_idx;
          end
        end
      end
      ST_DECIDE: begin
        is_arr <= arrival_c;
        beyond <= beyond_c;
        target <= target_c;
        dt     <= (target_c > current_time) ? target_c - current_time : '0;
        excess <= (cnt_ext > c_ext) ? MUL_A_BITS'(cnt_ext - c_ext) : '0;
      end
      ST_UPDATE: begin
        if (!beyond) begin
          if (is_arr) begin
            ev_kind <= KIND_ARRIVAL;
            took_a  <= 1'b1;
            dropped <= (customer_count == COUNT_MAX);
            took_s  <= (customer_count != COUNT_MAX) && (inc_ext <= c_ext) && idle_found;
          end else begin
            ev_kind <= KIND_DEPARTURE;
            took_s  <= (dec_ext >= c_ext);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUTPUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUTPUT && out_free) begin
      out_kind     <= ev_kind;
      out_time     <= current_time;
      out_in_sys   <= IN_SYS_BITS'(customer_count);
      out_served   <= departure_total;
      out_area     <= count_area;
      out_queue    <= waiting_area;
      out_busy     <= full_busy_total;
      out_took_a   <= took_a;
      out_took_s   <= took_s;
      out_dropped  <= dropped;
      out_finished <= (current_time >= end_time);
    end
  end

  // pack the result word
  assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_finished, out_dropped, out_took_s,
                         out_took_a, out_busy, out_queue, out_area, out_served,
                         out_in_sys, out_time};
  assign m_axis_tuser = out_kind;

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the multi-server queue event stepper
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mmcq_pkg::*;

  localparam int SERVER_SLOTS = DEF_SERVERS;
  localparam int COUNT_MAX    = (1 << DEF_COUNT_BITS) - 1;
  localparam int ROW_COUNT    = 26;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 95;

  // result word as it leaves the block, lowest field last
  typedef struct packed {
    logic [OUT_PAD_BITS-1:0] pad;
    logic                    finished;
    logic                    arrival_dropped;
    logic                    took_service_sample;
    logic                    took_arrival_sample;
    logic [ACC_BITS-1:0]     busy_sum;
    logic [ACC_BITS-1:0]     queue_area;
    logic [ACC_BITS-1:0]     area_sum;
    logic [DEP_BITS-1:0]     served_count;
    logic [IN_SYS_BITS-1:0]  in_system;
    logic [TIME_BITS-1:0]    event_time;
  } out_word_t;

  typedef struct packed {
    kind_t     kind;
    out_word_t word;
  } event_record_t;

  // register changes made ahead of a directed row
  typedef enum logic [1:0] {
    SETUP_NONE,
    SETUP_STOP_AT_ZERO,
    SETUP_STOP_NEXT_TICK,
    SETUP_WIDE_OPEN
  } setup_t;

  typedef struct {
    setup_t                 setup;
    logic [SAMPLE_BITS-1:0] gap;
    logic [SAMPLE_BITS-1:0] draw;
    bit                     fixed_exp;
    kind_t                  kind;
    logic [IN_SYS_BITS-1:0] in_sys;
    bit                     took_a;
    bit                     took_s;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SERVER_COUNT;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [KIND_BITS-1:0]      m_axis_tuser;

  int send_idle_pct = 19;
  int recv_idle_pct = 75;
  int mismatches = 0;

  // queue state mirror
  logic [TIME_BITS-1:0] free_at [SERVER_SLOTS];
  logic [TIME_BITS-1:0] next_arrival;
  logic [TIME_BITS-1:0] model_time;
  logic [TIME_BITS-1:0] busy_since;
  logic [TIME_BITS-1:0] stop_time;
  logic [SC_BITS-1:0]   server_cfg;
  logic [DEP_BITS-1:0]  served_total;
  logic [ACC_BITS-1:0]  count_integral;
  logic [ACC_BITS-1:0]  wait_integral;
  logic [ACC_BITS-1:0]  busy_total;
  int                   queue_len;

  event_record_t pending_events[$];

  // opening sequence: arrivals, waiting, ties, stop time, server count limits
  directed_row_t opening_rows [ROW_COUNT] = '{
    '{SETUP_NONE, 32'h0001_0000, 32'h0003_0000, 1'b1, KIND_ARRIVAL,   16'd1, 1'b1, 1'b1},
    '{SETUP_NONE, 32'h0001_0000, 32'h0003_0000, 1'b1, KIND_ARRIVAL,   16'd2, 1'b1, 1'b1},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_ARRIVAL,   16'd3, 1'b1, 1'b0},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_ARRIVAL,   16'd4, 1'b1, 1'b0},
    '{SETUP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_ARRIVAL,   16'd5, 1'b1, 1'b0},
    '{SETUP_NONE, 32'h0000_0000, 32'h0001_0000, 1'b1, KIND_DEPARTURE, 16'd4, 1'b0, 1'b1},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_DEPARTURE, 16'd3, 1'b0, 1'b1},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_DEPARTURE, 16'd2, 1'b0, 1'b1},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_DEPARTURE, 16'd1, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0000, 32'h1234_5678, 1'b1, KIND_DEPARTURE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0004_0000, 32'h0004_0000, 1'b1, KIND_ARRIVAL,   16'd1, 1'b1, 1'b1},
    '{SETUP_NONE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, KIND_DEPARTURE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_ARRIVAL,   16'd1, 1'b1, 1'b1},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_DEPARTURE, 16'd0, 1'b0, 1'b0},
    '{SETUP_STOP_AT_ZERO, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_STOP_NEXT_TICK, 32'h0001_0000, 32'h0002_0000, 1'b1, KIND_ARRIVAL, 16'd1,
      1'b1, 1'b1},
    '{SETUP_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, KIND_NONE, 16'd1, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_NONE, 16'd1, 1'b0, 1'b0},
    '{SETUP_WIDE_OPEN, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0010, 32'h1000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0},
    '{SETUP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 16'd0, 1'b0, 1'b0}
  };

  multi_server_queue_event_stepper dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ACC_BITS-1:0] sat_add(logic [ACC_BITS-1:0] a,
                                                   logic [ACC_BITS-1:0] b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_BITS] ? '1 : s[ACC_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] capped_add(logic [TIME_BITS-1:0] t,
                                                      logic [SAMPLE_BITS-1:0] d,
                                                      logic [TIME_BITS-1:0] cap);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS+1)'(d);
    return (s > {1'b0, cap}) ? cap : s[TIME_BITS-1:0];
  endfunction

  // grow the count and waiting integrals up to time t
  function automatic void integrate_to(logic [TIME_BITS-1:0] t, int c);
    logic [TIME_BITS-1:0] dt;
    dt = (t > model_time) ? t - model_time : '0;
    count_integral = sat_add(count_integral, 64'(queue_len) * 64'(dt));
    if (queue_len > c)
      wait_integral = sat_add(wait_integral, 64'(queue_len - c) * 64'(dt));
    model_time = t;
  endfunction

  function automatic void mirror_reset();
    foreach (free_at[i]) free_at[i] = IDLE_MARK;
    next_arrival   = '0;
    model_time     = '0;
    busy_since     = '0;
    queue_len      = 0;
    served_total   = '0;
    count_integral = '0;
    wait_integral  = '0;
    busy_total     = '0;
    server_cfg     = RESET_SERVER_COUNT;
    stop_time      = RESET_END_TIME;
  endfunction

  // one simulation event: arrival, departure or none, and the word it yields
  function automatic event_record_t queue_step(logic [SAMPLE_BITS-1:0] gap,
                                               logic [SAMPLE_BITS-1:0] draw);
    event_record_t        rec;
    int                   c, k, j;
    logic [TIME_BITS-1:0] earliest, t;
    bit                   arrival, placed;
    rec = '0;
    rec.kind = KIND_NONE;
    c = (server_cfg == 0) ? 1 :
        (server_cfg > SERVER_SLOTS) ? SERVER_SLOTS : int'(server_cfg);
    if (model_time < stop_time) begin
      // earliest busy active server, lowest index wins a tie
      earliest = IDLE_MARK;
      k = 0;
      for (j = 0; j < c; j++)
        if (free_at[j] < earliest) begin
          earliest = free_at[j];
          k = j;
        end
      arrival = (earliest == IDLE_MARK) || (next_arrival < earliest);
      t = arrival ? next_arrival : earliest;
      if (t >= stop_time) begin
        integrate_to(stop_time, c);
      end else if (arrival) begin
        integrate_to(t, c);
        rec.kind = KIND_ARRIVAL;
        rec.word.took_arrival_sample = 1'b1;
        next_arrival = capped_add(t, gap, TIME_MASK);
        if (queue_len >= COUNT_MAX) begin
          rec.word.arrival_dropped = 1'b1;
        end else begin
          queue_len++;
          if (queue_len <= c) begin
            if (queue_len == c) busy_since = t;
            placed = 1'b0;
            for (j = 0; j < c; j++)
              if (!placed && free_at[j] == IDLE_MARK) begin
                free_at[j] = capped_add(t, draw, FINISH_MAX);
                placed = 1'b1;
              end
            rec.word.took_service_sample = placed;
          end
        end
      end else begin
        integrate_to(t, c);
        rec.kind = KIND_DEPARTURE;
        if (queue_len > 0) begin
          if (queue_len == c && t >= busy_since)
            busy_total = sat_add(busy_total, 64'(t - busy_since));
          queue_len--;
        end
        if (served_total != '1) served_total++;
        free_at[k] = IDLE_MARK;
        // a waiting customer takes the freed server
        if (queue_len >= c) begin
          free_at[k] = capped_add(t, draw, FINISH_MAX);
          rec.word.took_service_sample = 1'b1;
        end
      end
    end
    rec.word.event_time   = model_time;
    rec.word.in_system    = queue_len[IN_SYS_BITS-1:0];
    rec.word.served_count = served_total;
    rec.word.area_sum     = count_integral;
    rec.word.queue_area   = wait_integral;
    rec.word.busy_sum     = busy_total;
    rec.word.finished     = (model_time >= stop_time);
    return rec;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample(int scale);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(0, (1 << scale) - 1);
    endcase
  endfunction

  function automatic void compare_field(string name, logic [ACC_BITS-1:0] want,
                                        logic [ACC_BITS-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // register write while the block is idle, mirrored once it has landed
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SERVER_COUNT: server_cfg = value[SC_BITS-1:0];
      REG_END_TIME:     stop_time = value[TIME_BITS-1:0];
      default: ;
    endcase
  endtask

  // offer one word, keeping valid high when the next follows at once
  task automatic send_word(input event_record_t rec, input logic [SAMPLE_BITS-1:0] gap,
                           input logic [SAMPLE_BITS-1:0] draw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    pending_events.push_back(rec);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {draw, gap};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // result side: random back-pressure and in-order checking
  always @(posedge clk) begin : result_check
    event_record_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.word = out_word_t'(m_axis_tdata);
      got.kind = kind_t'(m_axis_tuser);
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing pending, got %0h", $time, m_axis_tdata);
      end else begin
        want = pending_events.pop_front();
        compare_field("event_kind", 64'(want.kind), 64'(got.kind));
        compare_field("event_time", 64'(want.word.event_time), 64'(got.word.event_time));
        compare_field("in_system", 64'(want.word.in_system), 64'(got.word.in_system));
        compare_field("served_count", 64'(want.word.served_count),
                      64'(got.word.served_count));
        compare_field("area_sum", want.word.area_sum, got.word.area_sum);
        compare_field("queue_area", want.word.queue_area, got.word.queue_area);
        compare_field("busy_sum", want.word.busy_sum, got.word.busy_sum);
        compare_field("took_arrival_sample", 64'(want.word.took_arrival_sample),
                      64'(got.word.took_arrival_sample));
        compare_field("took_service_sample", 64'(want.word.took_service_sample),
                      64'(got.word.took_service_sample));
        compare_field("arrival_dropped", 64'(want.word.arrival_dropped),
                      64'(got.word.arrival_dropped));
        compare_field("finished", 64'(want.word.finished), 64'(got.word.finished));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // stimulus
  initial begin : stimulus
    directed_row_t          row;
    event_record_t          rec;
    logic [SAMPLE_BITS-1:0] gap, draw;
    logic [SC_BITS-1:0]     sc;
    logic [TIME_BITS-1:0]   stop;
    int                     gap_scale, draw_scale, drops, fill_items;
    mirror_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      case (row.setup)
        SETUP_STOP_AT_ZERO: begin
          wait_drain();
          write_reg(REG_END_TIME, '0);
        end
        SETUP_STOP_NEXT_TICK: begin
          wait_drain();
          write_reg(REG_END_TIME, model_time + 48'd1);
          write_reg(REG_SERVER_COUNT, '0);
        end
        SETUP_WIDE_OPEN: begin
          wait_drain();
          write_reg(REG_END_TIME, TIME_MASK);
          write_reg(REG_SERVER_COUNT, 48'd15);
        end
        default: ;
      endcase
      rec = queue_step(row.gap, row.draw);
      if (row.fixed_exp) begin
        rec.kind = row.kind;
        rec.word.in_system = row.in_sys;
        rec.word.took_arrival_sample = row.took_a;
        rec.word.took_service_sample = row.took_s;
      end
      send_word(rec, row.gap, row.draw);
    end

    // random phases, each with its own server count, stop time and load
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      case (p)
        0:       sc = 4'd0;
        1:       sc = 4'd1;
        2:       sc = 4'd8;
        3:       sc = 4'd15;
        default: sc = SC_BITS'($urandom_range(0, 15));
      endcase
      if (p % 5 == 4)
        stop = model_time + 48'($urandom_range(32'h0400_0000, 32'hFFFF_FFFF));
      else
        stop = TIME_MASK;
      write_reg(REG_SERVER_COUNT, 48'(sc));
      write_reg(REG_END_TIME, stop);
      send_idle_pct = (p < 5) ? 19 : (p < 10) ? 75 : 0;
      recv_idle_pct = (p < 5) ? 75 : (p < 10) ? 19 : 0;
      gap_scale  = $urandom_range(8, 22);
      draw_scale = gap_scale + $urandom_range(0, 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        gap  = random_sample(gap_scale);
        draw = random_sample(draw_scale);
        rec  = queue_step(gap, draw);
        send_word(rec, gap, draw);
      end
    end

    // single server held busy while arrivals pile up
    wait_drain();
    write_reg(REG_SERVER_COUNT, 48'd1);
    write_reg(REG_END_TIME, TIME_MASK);
    drops = 0;
    fill_items = 0;
    while (drops < 3 && fill_items < 40) begin
      rec = queue_step('0, '1);
      if (rec.word.arrival_dropped) drops++;
      send_word(rec, '0, '1);
      fill_items++;
    end

    // drain the full system for a while under a near stop time
    wait_drain();
    write_reg(REG_SERVER_COUNT, 48'd3);
    write_reg(REG_END_TIME, model_time + 48'h10_0000_0000);
    for (int n = 0; n < 20; n++) begin
      gap  = $urandom();
      draw = $urandom();
      rec  = queue_step(gap, draw);
      send_word(rec, gap, draw);
    end

    wait_drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
